// File: design/stior_pkg.sv
// stior_pkg: shared constants, opcodes and control/status types for the
// stream table in-order receiver. No dependencies.
`default_nettype none

package stior_pkg;

    localparam int MAX_STREAMS = 16;
    localparam int SLOT_W      = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int CNT_W       = $clog2(MAX_STREAMS + 1);

    localparam int OP_W       = 2;
    localparam int CONN_W     = 16;
    localparam int SEQ_W      = 32;
    localparam int LEN_W      = 16;
    localparam int CAP_W      = 20;
    localparam int SLOT_OUT_W = 4;
    localparam int ACT_W      = 5;

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 64;

    localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
    localparam logic [OP_W-1:0] OP_DATA    = 2'd2;
    localparam logic [OP_W-1:0] OP_OTHER   = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic match_en;
        logic read_en;
        logic commit;
    } stior_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } stior_sts_t;

endpackage

`default_nettype wire

// File: design/stior_ctrl.sv
// stior_ctrl: per-word sequencer (accept, match, read, commit).
// Depends on stior_pkg.
`default_nettype none

module stior_ctrl
    import stior_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire stior_sts_t sts,
    output stior_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MATCH = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                cmd.match_en = 1'b1;
                state_next   = ST_READ;
            end
            ST_READ:
            begin
                cmd.read_en = 1'b1;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // wait for the output register to free up
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: design/stior_dp.sv
// stior_dp: stream table, id match, receive-window update and output register.
// Depends on stior_pkg; sequenced by stior_ctrl.
`default_nettype none

module stior_dp
    import stior_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire stior_cmd_t          cmd,
    output stior_sts_t               sts,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [OP_W-1:0]     s_tuser,
    input  wire logic                cfg_wr_en,
    input  wire logic [CAP_W-1:0]    cfg_wr_data,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tuser
);

    // configuration
    logic [CAP_W-1:0] cap_reg;

    // slot table
    logic [MAX_STREAMS-1:0] valid_reg;
    logic [CONN_W-1:0]      conn_tab_reg [MAX_STREAMS];
    logic [SEQ_W-1:0]       exp_tab_reg  [MAX_STREAMS];
    logic [CAP_W-1:0]       fill_tab_reg [MAX_STREAMS];
    logic [CNT_W-1:0]       total_reg;
    logic [CNT_W-1:0]       total_next;

    // latched word
    logic [OP_W-1:0]   op_reg;
    logic [CONN_W-1:0] conn_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [LEN_W-1:0]  plen_reg;

    // match stage
    logic [MAX_STREAMS-1:0] match_vec;
    logic [SLOT_W-1:0]      hit_idx;
    logic [SLOT_W-1:0]      free_idx;
    logic                   hit_reg;
    logic [SLOT_W-1:0]      hit_idx_reg;
    logic                   free_any_reg;
    logic [SLOT_W-1:0]      free_idx_reg;

    // read stage
    logic [SLOT_W-1:0] sel_reg;
    logic              found_reg;
    logic [SEQ_W-1:0]  exp_cur_reg;
    logic [CAP_W-1:0]  fill_cur_reg;
    logic [CAP_W-1:0]  space_reg;
    logic              in_order_reg;
    logic [SLOT_W-1:0] sel_comb;
    logic [SEQ_W-1:0]  exp_rd;
    logic [CAP_W-1:0]  fill_rd;

    // commit stage
    logic              is_destroy;
    logic              is_data;
    logic              take;
    logic [LEN_W-1:0]  copied;
    logic [SEQ_W-1:0]  exp_new;
    logic [CAP_W-1:0]  fill_new;
    logic              res_status;
    logic [SLOT_OUT_W-1:0] res_slot;
    logic              res_existed;
    logic              res_ackv;
    logic [SEQ_W-1:0]  res_ackn;
    logic [LEN_W-1:0]  res_copied;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= s_tuser;
            conn_reg <= s_tdata[CONN_W-1:0];
            seq_reg  <= s_tdata[CONN_W+SEQ_W-1:CONN_W];
            plen_reg <= s_tdata[CONN_W+SEQ_W+LEN_W-1:CONN_W+SEQ_W];
        end
    end

    // parallel id compare, lowest index wins
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < MAX_STREAMS; i++)
        begin
            match_vec[i] = valid_reg[i] && (conn_tab_reg[i] == conn_reg);
        end
        for (int i = MAX_STREAMS - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_idx = SLOT_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.match_en)
        begin
            hit_reg      <= |match_vec;
            hit_idx_reg  <= hit_idx;
            free_any_reg <= ~&valid_reg;
            free_idx_reg <= free_idx;
        end
    end

    assign sel_comb = hit_reg ? hit_idx_reg : free_idx_reg;
    assign exp_rd   = hit_reg ? exp_tab_reg[sel_comb]  : SEQ_W'(1);
    assign fill_rd  = hit_reg ? fill_tab_reg[sel_comb] : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.read_en)
        begin
            sel_reg      <= sel_comb;
            found_reg    <= hit_reg || ((op_reg != OP_DESTROY) && free_any_reg);
            exp_cur_reg  <= exp_rd;
            fill_cur_reg <= fill_rd;
            in_order_reg <= (seq_reg == exp_rd);
            space_reg    <= (fill_rd < cap_reg) ? (cap_reg - fill_rd) : '0;
        end
    end

    assign is_destroy = (op_reg == OP_DESTROY);
    assign is_data    = (op_reg == OP_DATA);
    assign take       = is_data && in_order_reg;
    assign exp_new    = take ? (exp_cur_reg + SEQ_W'(1)) : exp_cur_reg;
    assign fill_new   = fill_cur_reg + CAP_W'(copied);

    always_comb
    begin
        copied = '0;
        if (take)
        begin
            copied = (CAP_W'(plen_reg) < space_reg) ? plen_reg : space_reg[LEN_W-1:0];
        end
    end

    always_comb
    begin
        total_next  = total_reg;
        res_status  = 1'b0;
        res_slot    = '0;
        res_existed = 1'b0;
        res_ackv    = 1'b0;
        res_ackn    = '0;
        res_copied  = '0;
        if (is_destroy)
        begin
            if (found_reg)
            begin
                res_slot    = SLOT_OUT_W'(sel_reg);
                res_existed = 1'b1;
                if (total_reg != '0)
                begin
                    total_next = total_reg - CNT_W'(1);
                end
            end
        end
        else if (!found_reg)
        begin
            res_status = 1'b1;
        end
        else
        begin
            res_slot    = SLOT_OUT_W'(sel_reg);
            res_existed = hit_reg;
            if (!hit_reg)
            begin
                total_next = total_reg + CNT_W'(1);
            end
            if (is_data)
            begin
                res_ackv   = 1'b1;
                res_ackn   = exp_new;
                res_copied = copied;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            total_reg <= '0;
        end
        else if (cmd.commit && found_reg)
        begin
            valid_reg[sel_reg] <= !is_destroy;
            total_reg          <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && found_reg && !is_destroy)
        begin
            conn_tab_reg[sel_reg] <= conn_reg;
            exp_tab_reg[sel_reg]  <= exp_new;
            fill_tab_reg[sel_reg] <= fill_new;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            m_tuser_reg <= res_status;
            m_tdata_reg <= M_DATA_W'({ACT_W'(total_next), res_copied, res_ackn, res_ackv,
                                      res_existed, res_slot});
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign m_tuser      = m_tuser_reg;

endmodule

`default_nettype wire

// File: design/stream_table_in_order_receiver_top.sv
// stream_table_in_order_receiver_top: connection table with in-order receive
// and cumulative ack. Depends on stior_pkg, stior_ctrl, stior_dp.
//
//  channel | dir | handshake           | payload
//  s_*     | in  | s_tvalid/s_tready   | tuser: op; tdata: conn_id, seq, pkt_len
//  m_*     | out | m_tvalid/m_tready   | tuser: status; tdata: slot .. active_count
//  cfg_*   | in  | cfg_wr_en           | cfg_wr_data: recv_capacity
//
// Each word goes through accept, id match over all slots, slot read with
// window math, and commit. Commit waits while the output register is full and not
// being taken; a new word is accepted while a result sits in the output.
// Reset clears the slot valid bits, stream count and recv_capacity.
`default_nettype none

module stream_table_in_order_receiver_top
    import stior_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // conn_id[15:0], seq[47:16], pkt_len[63:48]
    input  wire logic [OP_W-1:0]     s_tuser,   // op[1:0]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // slot[3:0], existed[4], ack_valid[5],
                                                // ack_num[37:6], copied_len[53:38],
                                                // active_count[58:54], zero[63:59]
    output logic                     m_tuser,   // status[0]
    input  wire logic                cfg_wr_en,
    input  wire logic [CAP_W-1:0]    cfg_wr_data
);

    stior_cmd_t cmd;
    stior_sts_t sts;

    stior_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    stior_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire

// File: design/stior_checker.sv
// stior_checker: port-level assertions for the stream table receiver,
// bound to stream_table_in_order_receiver_top. Depends on stior_pkg.
`default_nettype none

module stior_checker
    import stior_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic                m_tuser
);

    // one word in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a word is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output changed");

    a_full_no_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (!m_tdata[5] && m_tdata[53:38] == 16'd0
                                   && m_tdata[4:0] == 5'd0))
        else $error("table-full result carries ack or slot");

    a_copy_needs_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[53:38] != 16'd0) |-> m_tdata[5])
        else $error("bytes copied without ack");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[58:54] <= 5'(MAX_STREAMS)))
        else $error("active count above table size");

endmodule

bind stream_table_in_order_receiver_top stior_checker u_stior_checker (.*);

`default_nettype wire

// File: verif/stream_table_in_order_receiver_top_tb.sv
// Testbench for stream_table_in_order_receiver_top: queue-fed stream driver, checking
// monitor and a behavioral predictor of the stream table, in one module.
// Depends on stior_pkg and the design sources only.
module stream_table_in_order_receiver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stior_pkg::*;

    localparam int POOL_SZ    = 24;
    localparam int HOLD_LEN   = 150;
    localparam int QUIET_MAX  = 2000;
    localparam int SETTLE_CYC = 8;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CONN_W-1:0] conn;
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  len;
    } word_t;

    typedef struct packed {
        logic                  status;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  existed;
        logic                  ack_valid;
        logic [SEQ_W-1:0]      ack_num;
        logic [LEN_W-1:0]      copied;
        logic [ACT_W-1:0]      active;
        logic [4:0]            pad;
    } ack_t;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata     = '0;
    logic [OP_W-1:0]     s_tuser     = '0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]    cfg_wr_data = '0;

    stream_table_in_order_receiver_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // predicted stream table
    bit               tbl_valid [MAX_STREAMS];
    logic [CONN_W-1:0] tbl_conn  [MAX_STREAMS];
    logic [SEQ_W-1:0]  tbl_exp   [MAX_STREAMS];
    logic [CAP_W-1:0]  tbl_fill  [MAX_STREAMS];
    int unsigned       tbl_count = 0;
    logic [CAP_W-1:0]  recv_cap  = '0;

    word_t       word_q[$];
    ack_t        ack_due_q[$];
    word_t       cur_word;
    logic [CONN_W-1:0] id_pool [POOL_SZ];

    bit          gaps_on    = 1'b1;
    int          hold_reqs  = 0;
    int          hold_seen  = 0;
    int          hold_cnt   = 0;
    int          stall_cnt  = 0;
    int          gap_cnt    = 0;
    int          quiet_cyc  = 0;
    int          n_fail     = 0;
    int          n_words    = 0;
    int          n_checked  = 0;
    int          n_full     = 0;
    int          n_caps     = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one word to the predicted table and returns the result it causes.
    function automatic ack_t stream_table_apply(word_t w);
        ack_t             r;
        int               s;
        logic [CAP_W-1:0] space;
        logic [CAP_W-1:0] take;
        r = '0;
        s = -1;
        for (int i = 0; i < MAX_STREAMS; i++)
            if (s < 0 && tbl_valid[i] && tbl_conn[i] == w.conn)
                s = i;
        if (w.op == OP_DESTROY)
        begin
            if (s >= 0)
            begin
                tbl_valid[s] = 1'b0;
                if (tbl_count > 0)
                    tbl_count--;
                r.slot    = s[SLOT_OUT_W-1:0];
                r.existed = 1'b1;
            end
        end
        else
        begin
            if (s >= 0)
                r.existed = 1'b1;
            else
                for (int i = 0; i < MAX_STREAMS; i++)
                    if (s < 0 && !tbl_valid[i])
                    begin
                        s            = i;
                        tbl_valid[i] = 1'b1;
                        tbl_conn[i]  = w.conn;
                        tbl_exp[i]   = 32'd1;
                        tbl_fill[i]  = '0;
                        tbl_count++;
                    end
            if (s < 0)
                r.status = 1'b1;
            else
            begin
                r.slot = s[SLOT_OUT_W-1:0];
                if (w.op == OP_DATA)
                begin
                    if (w.seq == tbl_exp[s])
                    begin
                        if (recv_cap != 0 && w.len != 0)
                        begin
                            space = (tbl_fill[s] < recv_cap) ? recv_cap - tbl_fill[s] : '0;
                            take  = ({4'd0, w.len} < space) ? {4'd0, w.len} : space;
                            r.copied    = take[LEN_W-1:0];
                            tbl_fill[s] = tbl_fill[s] + take;
                        end
                        tbl_exp[s] = tbl_exp[s] + 32'd1;
                    end
                    r.ack_valid = 1'b1;
                    r.ack_num   = tbl_exp[s];
                end
            end
        end
        r.active = tbl_count[ACT_W-1:0];
        return r;
    endfunction

    // Mostly in-order data on a small id pool, with some noise.
    function automatic word_t random_word();
        word_t       w;
        int unsigned r;
        int          s;
        int          ahead;
        r      = $urandom_range(0, 99);
        w.conn = id_pool[$urandom_range(0, POOL_SZ - 1)];
        w.seq  = $urandom;
        w.len  = LEN_W'($urandom);
        if (r < 55)
        begin
            w.op  = OP_DATA;
            s     = -1;
            ahead = 0;
            for (int i = 0; i < MAX_STREAMS; i++)
                if (s < 0 && tbl_valid[i] && tbl_conn[i] == w.conn)
                    s = i;
            foreach (word_q[i])
                if (word_q[i].op == OP_DATA && word_q[i].conn == w.conn)
                    ahead++;
            if (s_tvalid && cur_word.op == OP_DATA && cur_word.conn == w.conn)
                ahead++;
            case ($urandom_range(0, 9))
                0:       w.seq = $urandom;
                1:       w.seq = ((s >= 0) ? tbl_exp[s] : 32'd1) + ahead - 1;
                default: w.seq = ((s >= 0) ? tbl_exp[s] : 32'd1) + ahead;
            endcase
            case ($urandom_range(0, 9))
                0, 1:    w.len = LEN_W'($urandom_range(0, 15));
                2:       w.len = '1;
                3:       w.len = LEN_W'($urandom);
                default: w.len = LEN_W'($urandom_range(0, 2000));
            endcase
        end
        else if (r < 66)
            w.op = OP_CREATE;
        else if (r < 81)
            w.op = OP_DESTROY;
        else if (r < 90)
            w.op = OP_OTHER;
        else
        begin
            w.op   = OP_W'($urandom_range(0, 3));
            w.conn = CONN_W'($urandom);
        end
        return w;
    endfunction

    task automatic queue_word(input logic [OP_W-1:0] op, input logic [CONN_W-1:0] conn,
                              input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len);
        word_t w;
        w.op   = op;
        w.conn = conn;
        w.seq  = seq;
        w.len  = len;
        word_q.push_back(w);
    endtask

    task automatic drain;
        while (word_q.size() != 0 || s_tvalid || ack_due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        recv_cap    = v;
        n_caps++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            n_fail++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_cnt  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                ack_due_q.push_back(stream_table_apply(cur_word));
                if (ack_due_q[$].status)
                    n_full++;
                n_words++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_cnt > 0)
                begin
                    gap_cnt--;
                    s_tvalid <= 1'b0;
                end
                else if (word_q.size() != 0)
                begin
                    cur_word = word_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_word.len, cur_word.seq, cur_word.conn};
                    s_tuser  <= cur_word.op;
                    if (gaps_on && $urandom_range(0, 4) == 0)
                        gap_cnt = $urandom_range(1, 3);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : rx
        ack_t want;
        ack_t got;
        bit   rdy;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata[3:0], m_tdata[4], m_tdata[5], m_tdata[37:6],
                       m_tdata[53:38], m_tdata[58:54], m_tdata[63:59]};
                if (ack_due_q.size() == 0)
                begin
                    n_fail++;
                    $display("%0t: unexpected result, expected none actual %h/%h",
                             $time, m_tuser, m_tdata);
                end
                else
                begin
                    want = ack_due_q.pop_front();
                    n_checked++;
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("slot", 32'(want.slot), 32'(got.slot));
                    check_field("existed", 32'(want.existed), 32'(got.existed));
                    check_field("ack_valid", 32'(want.ack_valid), 32'(got.ack_valid));
                    check_field("ack_num", want.ack_num, got.ack_num);
                    check_field("copied_len", 32'(want.copied), 32'(got.copied));
                    check_field("active_count", 32'(want.active), 32'(got.active));
                    check_field("tdata pad", 32'(want.pad), 32'(got.pad));
                end
            end
            rdy = 1'b1;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rdy = 1'b0;
            end
            else if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_cnt  = HOLD_LEN;
                rdy       = 1'b0;
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt--;
                rdy = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                stall_cnt = $urandom_range(0, 2);
                rdy       = 1'b0;
            end
            m_tready <= rdy;
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cyc = 0;
        else
            quiet_cyc++;
        if (quiet_cyc >= QUIET_MAX)
        begin
            $display("timeout: no word moved for %0d cycles", QUIET_MAX);
            $display("stream_table_in_order_receiver_top verification failed");
            $finish;
        end
    end

    initial
    begin : stim
        logic [CAP_W-1:0] caps [6];
        word_t            w;
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        id_pool[2] = 16'h00FF;
        id_pool[3] = 16'h1234;
        id_pool[4] = 16'h5A5A;
        for (int i = 0; i < 12; i++)
            id_pool[5 + i] = CONN_W'(16'h1000 + i);
        for (int i = 17; i < POOL_SZ; i++)
            id_pool[i] = CONN_W'($urandom);
        caps = '{20'hFFFFF, 20'd300, 20'd1, 20'd0, 20'h10000, 20'd0};
        caps[5] = CAP_W'($urandom);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_capacity(20'd1000);
        queue_word(OP_CREATE,  16'h0000, 32'h0, 16'h0);
        queue_word(OP_CREATE,  16'h0000, 32'hFFFFFFFF, 16'hFFFF);   // already open
        queue_word(OP_CREATE,  16'hFFFF, 32'h0, 16'h0);
        queue_word(OP_DATA,    16'h0000, 32'd1, 16'hFFFF);          // clamped to capacity
        queue_word(OP_DATA,    16'h0000, 32'd1, 16'd5);             // duplicate
        queue_word(OP_DATA,    16'h0000, 32'hFFFFFFFF, 16'd5);      // out of order
        queue_word(OP_DATA,    16'h0000, 32'd2, 16'd0);             // empty payload
        queue_word(OP_DATA,    16'h0000, 32'd3, 16'd7);             // buffer full
        queue_word(OP_OTHER,   16'hFFFF, 32'd0, 16'd9);
        queue_word(OP_OTHER,   16'h1234, 32'd0, 16'd9);             // opens on other
        queue_word(OP_DATA,    16'h5A5A, 32'd1, 16'd10);            // opens on data
        queue_word(OP_DESTROY, 16'hBEEF, 32'd0, 16'd0);             // unknown id
        queue_word(OP_DESTROY, 16'hFFFF, 32'd0, 16'd0);
        queue_word(OP_CREATE,  16'h00FF, 32'd0, 16'd0);             // reuses freed slot
        for (int i = 0; i < 12; i++)
            queue_word(OP_CREATE, CONN_W'(16'h1000 + i), 32'd0, 16'd0);
        queue_word(OP_CREATE,  16'h7777, 32'd0, 16'd0);             // table full
        queue_word(OP_DATA,    16'h7778, 32'd1, 16'd4);
        queue_word(OP_OTHER,   16'h7779, 32'd0, 16'd4);

        set_capacity(20'd10);
        queue_word(OP_DATA,    16'h0000, 32'd4, 16'd20);            // fill over capacity
        queue_word(OP_DESTROY, 16'h1000, 32'd0, 16'd0);
        set_capacity(20'd0);
        queue_word(OP_DATA,    16'h5A5A, 32'd2, 16'd100);           // no buffer

        for (int ph = 0; ph < 6; ph++)
        begin
            set_capacity(caps[ph]);
            gaps_on = (ph != 5);
            for (int n = 0; n < 85; n++)
            begin
                if (ph != 5 && n % 30 == 0)
                    gaps_on = $urandom_range(0, 3) != 0;
                if ((ph == 1 || ph == 4) && n == 30)
                    hold_reqs++;
                while (word_q.size() >= 2)
                    @(posedge clk);
                w = random_word();
                word_q.push_back(w);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("run: %0d words sent, %0d results checked, %0d with table full,",
                 n_words, n_checked, n_full);
        $display("     %0d capacity settings, two long receiver hold-offs", n_caps);
        if (n_fail == 0 && ack_due_q.size() == 0)
            $display("stream_table_in_order_receiver_top verification clean");
        else
            $display("stream_table_in_order_receiver_top verification failed");
        $finish;
    end

endmodule

// File: filelist.f
design/stior_pkg.sv
design/stior_ctrl.sv
design/stior_dp.sv
design/stream_table_in_order_receiver_top.sv
design/stior_checker.sv
verif/stream_table_in_order_receiver_top_tb.sv
